### src/uhd_pkg.sv
// ============================================================================
// uhd_pkg
// Shared types and constants for the UTF-8 decoder with Hangul decomposition.
// ============================================================================
package uhd_pkg;

    // Queue depths between the front end, the back end and the result port.
    localparam int CMD_DEPTH = 4;
    localparam int OUT_DEPTH = 4;

    // Code point width and the Hangul syllable block.
    localparam int CP_W = 21;
    localparam logic [CP_W-1:0] HANGUL_FIRST = 21'h00AC00;
    localparam logic [CP_W-1:0] HANGUL_LAST  = 21'h00D7A3;

    // Conjoining jamo bases.
    localparam logic [15:0] JAMO_L_BASE = 16'h1100;
    localparam logic [15:0] JAMO_V_BASE = 16'h1161;
    localparam logic [15:0] JAMO_T_BASE = 16'h11A7;

    // Reciprocals for the divisions by 28 (scaled by 2^18) and by 21 (scaled
    // by 2^16). Exact for syllable offsets below 11172 and quotients below 399.
    localparam logic [13:0] RECIP_28 = 14'd9363;
    localparam logic [11:0] RECIP_21 = 12'd3121;

    // Lead byte patterns: mask and match for two, three and four byte forms.
    localparam logic [7:0] LEAD2_MASK  = 8'hE0;
    localparam logic [7:0] LEAD2_MATCH = 8'hC0;
    localparam logic [7:0] LEAD3_MASK  = 8'hF0;
    localparam logic [7:0] LEAD3_MATCH = 8'hE0;
    localparam logic [7:0] LEAD4_MASK  = 8'hF8;
    localparam logic [7:0] LEAD4_MATCH = 8'hF0;

    // Classified code point handed from the front end to the back end.
    // For a syllable, value holds the offset from the start of the block.
    typedef struct packed {
        logic        hangul;
        logic [15:0] value;
    } cmd_t;

    // One result item.
    typedef struct packed {
        logic [15:0] value;
        logic        last;
    } unit_t;

endpackage

### src/uhd_fifo.sv
// ============================================================================
// uhd_fifo
// Small synchronous queue with registered storage and an occupancy count.
// ============================================================================
module uhd_fifo
    import uhd_pkg::*;
#(
    parameter int WIDTH = 17,
    parameter int DEPTH = 4
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = mem[rd_ptr_reg];

    // Pointer and count updates; pointers wrap at the last entry.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr && !rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd && !wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

### src/uhd_front.sv
// ============================================================================
// uhd_front
// UTF-8 sequence tracker: gathers code points and classifies each one as a
// Hangul syllable or a plain code unit.
// ============================================================================
module uhd_front
    import uhd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] byte_in,
    input  logic       last_byte,
    output logic       cmd_wr,
    output cmd_t       cmd_data
);

    logic [CP_W-1:0] acc_reg, acc_next;
    logic [1:0]      rem_reg, rem_next;
    logic [CP_W-1:0] shifted;
    logic [CP_W-1:0] cp;
    logic [CP_W-1:0] offset;
    logic            done;

    assign shifted = {acc_reg[CP_W-7:0], byte_in[5:0]};
    assign offset  = cp - HANGUL_FIRST;

    // Sequence tracking: a lead byte opens a sequence, later bytes are
    // taken as continuations without checking them.
    always_comb
    begin
        acc_next = acc_reg;
        rem_next = rem_reg;
        cp       = {{(CP_W-8){1'b0}}, byte_in};
        done     = 1'b0;
        if (accept)
        begin
            if (rem_reg == 2'd0)
            begin
                priority if (!byte_in[7])
                begin
                    acc_next = '0;
                    done     = 1'b1;
                end
                else if ((byte_in & LEAD2_MASK) == LEAD2_MATCH)
                begin
                    acc_next = {{(CP_W-5){1'b0}}, byte_in[4:0]};
                    rem_next = 2'd1;
                end
                else if ((byte_in & LEAD3_MASK) == LEAD3_MATCH)
                begin
                    acc_next = {{(CP_W-4){1'b0}}, byte_in[3:0]};
                    rem_next = 2'd2;
                end
                else if ((byte_in & LEAD4_MASK) == LEAD4_MATCH)
                begin
                    acc_next = {{(CP_W-3){1'b0}}, byte_in[2:0]};
                    rem_next = 2'd3;
                end
                else
                begin
                    // Stray continuation or invalid lead byte: skipped.
                    acc_next = acc_reg;
                end
                // A lead byte that ends the text leaves nothing pending.
                if (byte_in[7] && last_byte)
                begin
                    acc_next = '0;
                    rem_next = 2'd0;
                end
            end
            else
            begin
                rem_next = rem_reg - 2'd1;
                if (rem_reg == 2'd1)
                begin
                    cp       = shifted;
                    done     = 1'b1;
                    acc_next = '0;
                end
                else if (last_byte)
                begin
                    acc_next = '0;
                    rem_next = 2'd0;
                end
                else
                begin
                    acc_next = shifted;
                end
            end
        end
    end

    // Classification of the finished code point.
    always_comb
    begin
        cmd_wr          = done;
        cmd_data.hangul = (cp >= HANGUL_FIRST) && (cp <= HANGUL_LAST);
        cmd_data.value  = cmd_data.hangul ? offset[15:0] : cp[15:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
            rem_reg <= 2'd0;
        end
        else
        begin
            acc_reg <= acc_next;
            rem_reg <= rem_next;
        end
    end

endmodule

### src/uhd_back.sv
// ============================================================================
// uhd_back
// Jamo splitter: two divide stages by reciprocal multiplication, then an
// expander that hands out one to three units, one per cycle unless out_full.
// ============================================================================
module uhd_back
    import uhd_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  cmd_empty,
    input  cmd_t  cmd_data,
    output logic  cmd_pop,
    input  logic  out_full,
    output logic  out_wr,
    output unit_t out_data
);

    // Stage one: offset divided by 28.
    logic        s1_v_reg, s1_v_next;
    cmd_t        s1_cmd_reg, s1_cmd_next;
    logic [8:0]  s1_q_reg, s1_q_next;

    // Stage two: quotient divided by 21, remainder by 28.
    logic        s2_v_reg, s2_v_next;
    cmd_t        s2_cmd_reg, s2_cmd_next;
    logic [8:0]  s2_q_reg, s2_q_next;
    logic [4:0]  s2_l_reg, s2_l_next;
    logic [4:0]  s2_t_reg, s2_t_next;

    // Expander holding the units still to be written.
    logic [1:0]  exp_cnt_reg, exp_cnt_next;
    logic [15:0] exp_u0_reg, exp_u0_next;
    logic [15:0] exp_u1_reg, exp_u1_next;
    logic [15:0] exp_u2_reg, exp_u2_next;

    logic [27:0] prod_28;
    logic [20:0] prod_21;
    logic [13:0] q_times_28;
    logic [13:0] t_full;
    logic [8:0]  l_times_21;
    logic [8:0]  v_full;
    logic        load_ok;
    logic        s2_adv;
    logic        s2_take;
    logic        s1_adv;
    logic        s1_take;

    // Handshake between stages.
    always_comb
    begin
        out_wr  = (exp_cnt_reg != 2'd0) && !out_full;
        load_ok = (exp_cnt_reg == 2'd0) || ((exp_cnt_reg == 2'd1) && out_wr);
        s2_adv  = s2_v_reg && load_ok;
        s2_take = !s2_v_reg || s2_adv;
        s1_adv  = s1_v_reg && s2_take;
        s1_take = !s1_v_reg || s1_adv;
        cmd_pop = !cmd_empty && s1_take;
    end

    // Arithmetic of the two divide stages and the final remainder.
    always_comb
    begin
        prod_28    = cmd_data.value[13:0] * RECIP_28;
        prod_21    = s1_q_reg * RECIP_21;
        q_times_28 = {s1_q_reg, 5'b0} - {3'b0, s1_q_reg, 2'b0};
        t_full     = s1_cmd_reg.value[13:0] - q_times_28;
        l_times_21 = {s2_l_reg, 4'b0} + {2'b0, s2_l_reg, 2'b0} + {4'b0, s2_l_reg};
        v_full     = s2_q_reg - l_times_21;
    end

    // Next values of the pipeline registers.
    always_comb
    begin
        s1_v_next   = s1_take ? cmd_pop : s1_v_reg;
        s1_cmd_next = cmd_pop ? cmd_data : s1_cmd_reg;
        s1_q_next   = cmd_pop ? prod_28[26:18] : s1_q_reg;

        s2_v_next   = s2_take ? s1_adv : s2_v_reg;
        s2_cmd_next = s1_adv ? s1_cmd_reg : s2_cmd_reg;
        s2_q_next   = s1_adv ? s1_q_reg : s2_q_reg;
        s2_l_next   = s1_adv ? prod_21[20:16] : s2_l_reg;
        s2_t_next   = s1_adv ? t_full[4:0] : s2_t_reg;
    end

    // Expander: load a new group or shift out the front unit.
    always_comb
    begin
        exp_cnt_next = exp_cnt_reg;
        exp_u0_next  = exp_u0_reg;
        exp_u1_next  = exp_u1_reg;
        exp_u2_next  = exp_u2_reg;
        if (s2_adv)
        begin
            if (s2_cmd_reg.hangul)
            begin
                exp_u0_next  = JAMO_L_BASE + {11'b0, s2_l_reg};
                exp_u1_next  = JAMO_V_BASE + {11'b0, v_full[4:0]};
                exp_u2_next  = JAMO_T_BASE + {11'b0, s2_t_reg};
                exp_cnt_next = (s2_t_reg != 5'd0) ? 2'd3 : 2'd2;
            end
            else
            begin
                exp_u0_next  = s2_cmd_reg.value;
                exp_cnt_next = 2'd1;
            end
        end
        else if (out_wr)
        begin
            exp_u0_next  = exp_u1_reg;
            exp_u1_next  = exp_u2_reg;
            exp_cnt_next = exp_cnt_reg - 2'd1;
        end
    end

    assign out_data.value = exp_u0_reg;
    assign out_data.last  = (exp_cnt_reg == 2'd1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg    <= 1'b0;
            s2_v_reg    <= 1'b0;
            exp_cnt_reg <= 2'd0;
        end
        else
        begin
            s1_v_reg    <= s1_v_next;
            s2_v_reg    <= s2_v_next;
            exp_cnt_reg <= exp_cnt_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        s1_cmd_reg <= s1_cmd_next;
        s1_q_reg   <= s1_q_next;
        s2_cmd_reg <= s2_cmd_next;
        s2_q_reg   <= s2_q_next;
        s2_l_reg   <= s2_l_next;
        s2_t_reg   <= s2_t_next;
        exp_u0_reg <= exp_u0_next;
        exp_u1_reg <= exp_u1_next;
        exp_u2_reg <= exp_u2_next;
    end

endmodule

### src/utf8_decode_hangul_decompose.sv
// A byte that completes a code point reaches the output through the command
// queue, both divide stages, the expander and the result queue. Throughput:
// one byte per cycle while the command queue has room; results leave at one
// unit per cycle when the result queue has room (single-unit expander port).
// Reset (rst_n, asynchronous, active low) clears the pending sequence, empties
// both queues and the pipeline.
// ============================================================================
// utf8_decode_hangul_decompose
// UTF-8 byte decoder that splits Hangul syllables into conjoining jamo.
// ============================================================================
module utf8_decode_hangul_decompose
    import uhd_pkg::*;
#(
    parameter int CMD_QUEUE_DEPTH = CMD_DEPTH,
    parameter int OUT_QUEUE_DEPTH = OUT_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  byte_in,
    input  logic        last_byte,
    output logic        empty,
    input  logic        pop,
    output logic [15:0] unit_value,
    output logic        last_of_run
);

    logic  accept;
    logic  cmd_wr;
    cmd_t  cmd_wdata;
    cmd_t  cmd_rdata;
    logic  cmd_empty;
    logic  cmd_pop;
    logic  out_wr;
    logic  out_full;
    unit_t out_wdata;
    unit_t out_rdata;

    assign accept = push && !full;

    // Front end: sequence tracking and classification.
    uhd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .byte_in   (byte_in),
        .last_byte (last_byte),
        .cmd_wr    (cmd_wr),
        .cmd_data  (cmd_wdata)
    );

    // Queue between front and back.
    uhd_fifo #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (CMD_QUEUE_DEPTH)
    ) u_cmd_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (cmd_wr),
        .wr_data (cmd_wdata),
        .full    (full),
        .rd      (cmd_pop),
        .rd_data (cmd_rdata),
        .empty   (cmd_empty)
    );

    // Back end: jamo splitting and unit expansion.
    uhd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_empty (cmd_empty),
        .cmd_data  (cmd_rdata),
        .cmd_pop   (cmd_pop),
        .out_full  (out_full),
        .out_wr    (out_wr),
        .out_data  (out_wdata)
    );

    // Result queue facing the consumer.
    uhd_fifo #(
        .WIDTH ($bits(unit_t)),
        .DEPTH (OUT_QUEUE_DEPTH)
    ) u_out_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (out_wr),
        .wr_data (out_wdata),
        .full    (out_full),
        .rd      (pop && !empty),
        .rd_data (out_rdata),
        .empty   (empty)
    );

    assign unit_value  = out_rdata.value;
    assign last_of_run = out_rdata.last;

    // The expander never writes into a full result queue.
    a_out_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        out_wr |-> !out_full)
        else $error("result queue written while full");

    // The back end only takes an item that the queue holds.
    a_cmd_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> !cmd_empty)
        else $error("command queue read while empty");

    // Results appear only after the back end has written one.
    a_no_phantom_result: assert property (@(posedge clk) disable iff (!rst_n)
        (empty && !out_wr) |=> empty)
        else $error("result appeared without a write");

endmodule

### tb/sv/jamo_unit_checker.sv
`timescale 1ns / 100ps
// ============================================================================
// jamo_unit_checker
// Watches the byte and unit channels of the UTF-8 decoder, predicts every
// code unit from the accepted bytes and compares the units that are popped.
// ============================================================================
module jamo_unit_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  logic        full,
    input  logic [7:0]  byte_in,
    input  logic        last_byte,
    input  logic        empty,
    input  logic        pop,
    input  logic [15:0] unit_value,
    input  logic        last_of_run,
    output int          failures,
    output int          open_units,
    output int          units_checked,
    output int          syllables_split,
    output int          tails_dropped,
    output int          bytes_skipped
);

    // Hangul syllable block and conjoining jamo bases.
    localparam logic [20:0] SYL_FIRST = 21'h00AC00;
    localparam int unsigned SYL_COUNT = 11172;
    localparam int unsigned LV_SPAN   = 588;
    localparam int unsigned T_SPAN    = 28;
    localparam logic [15:0] L_BASE    = 16'h1100;
    localparam logic [15:0] V_BASE    = 16'h1161;
    localparam logic [15:0] T_BASE    = 16'h11A7;

    typedef struct packed {
        logic [15:0] value;
        logic        closes_run;
    } code_unit_t;

    // Decoder state as predicted from the accepted bytes.
    logic [20:0] seq_acc;
    logic [1:0]  seq_left;
    code_unit_t  pending_units[$];
    int          fail_total;
    int          checked_total;
    int          syllable_total;
    int          dropped_total;
    int          skipped_total;

    assign failures        = fail_total;
    assign units_checked   = checked_total;
    assign syllables_split = syllable_total;
    assign tails_dropped   = dropped_total;
    assign bytes_skipped   = skipped_total;

    // Append one predicted unit behind the ones still waiting.
    function automatic void queue_unit(input code_unit_t u);
        pending_units.insert(pending_units.size(), u);
    endfunction

    // A complete code point becomes two or three jamo, or its low 16 bits.
    function automatic void split_code_point(input logic [20:0] cp);
        int unsigned ofs;
        int unsigned t_idx;
        if (cp >= SYL_FIRST && cp < SYL_FIRST + SYL_COUNT)
        begin
            ofs   = cp - SYL_FIRST;
            t_idx = ofs % T_SPAN;
            queue_unit(code_unit_t'{L_BASE + 16'(ofs / LV_SPAN), 1'b0});
            queue_unit(code_unit_t'{V_BASE + 16'((ofs % LV_SPAN) / T_SPAN),
                                    t_idx == 0});
            if (t_idx != 0)
            begin
                queue_unit(code_unit_t'{T_BASE + 16'(t_idx), 1'b1});
            end
            syllable_total++;
        end
        else
        begin
            queue_unit(code_unit_t'{cp[15:0], 1'b1});
        end
    endfunction

    // One accepted byte: start, extend or finish a sequence.
    function automatic void decode_byte(input logic [7:0] b, input logic fin);
        logic        lead;
        logic [20:0] cp;
        lead = 1'b0;
        if (seq_left == 2'd0)
        begin
            if (!b[7])
            begin
                seq_acc = '0;
                split_code_point({13'd0, b});
            end
            else if (b[7:5] == 3'b110)
            begin
                seq_acc  = {16'd0, b[4:0]};
                seq_left = 2'd1;
                lead     = 1'b1;
            end
            else if (b[7:4] == 4'b1110)
            begin
                seq_acc  = {17'd0, b[3:0]};
                seq_left = 2'd2;
                lead     = 1'b1;
            end
            else if (b[7:3] == 5'b11110)
            begin
                seq_acc  = {18'd0, b[2:0]};
                seq_left = 2'd3;
                lead     = 1'b1;
            end
            else
            begin
                skipped_total++;
            end
            // A lead byte marked last can never complete.
            if (lead && fin)
            begin
                seq_acc  = '0;
                seq_left = 2'd0;
                dropped_total++;
            end
        end
        else
        begin
            // Any byte counts as a continuation here; only its low six bits matter.
            seq_acc  = {seq_acc[14:0], b[5:0]};
            seq_left = seq_left - 2'd1;
            if (seq_left == 2'd0)
            begin
                cp      = seq_acc;
                seq_acc = '0;
                split_code_point(cp);
            end
            else if (fin)
            begin
                seq_acc  = '0;
                seq_left = 2'd0;
                dropped_total++;
            end
        end
    endfunction

    // Compare one popped unit with the oldest prediction.
    function automatic void check_unit();
        code_unit_t want;
        checked_total++;
        if (pending_units.size() == 0)
        begin
            fail_total++;
            if (fail_total <= 10)
            begin
                $display("ERROR: unit %h last %b popped with none predicted",
                         unit_value, last_of_run);
            end
        end
        else
        begin
            want = pending_units.pop_front();
            if (unit_value !== want.value || last_of_run !== want.closes_run)
            begin
                fail_total++;
                if (fail_total <= 10)
                begin
                    $display("ERROR: unit expected %h last %b, got %h last %b",
                             want.value, want.closes_run, unit_value, last_of_run);
                end
            end
        end
    endfunction

    // Both channels are sampled at the rising edge, before the drivers update.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_acc  = '0;
            seq_left = 2'd0;
            pending_units.delete();
            open_units <= 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                check_unit();
            end
            if (push && !full)
            begin
                decode_byte(byte_in, last_byte);
            end
            open_units <= pending_units.size();
        end
    end

    initial
    begin
        fail_total     = 0;
        checked_total  = 0;
        syllable_total = 0;
        dropped_total  = 0;
        skipped_total  = 0;
    end

endmodule

### tb/sv/utf8_decode_hangul_decompose_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// utf8_decode_hangul_decompose_tb
// Feeds UTF-8 text to the decoder: a directed set of edge cases, then random
// well-formed sequences mixed with noise and cut-off tails, with random gaps
// on both sides and one long hold on the unit side. A checker alongside the
// block predicts and compares every unit.
// ============================================================================
module utf8_decode_hangul_decompose_tb;

    localparam int RANDOM_BYTES = 200;
    localparam int QUIET_BYTES  = 40;
    localparam int HOLD_AFTER   = 60;
    localparam int HOLD_CYCLES  = 100;
    localparam int TAIL_CYCLES  = 16;
    localparam int RUN_LIMIT    = 200000;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [7:0]  byte_in;
    logic        last_byte;
    logic        empty;
    logic        pop;
    logic [15:0] unit_value;
    logic        last_of_run;

    int   failures;
    int   open_units;
    int   units_checked;
    int   syllables_split;
    int   tails_dropped;
    int   bytes_skipped;
    int   bytes_sent;
    int   stall_cycles;
    int   cycles_run;
    logic quiet_tail;
    logic hold_done;

    utf8_decode_hangul_decompose u_dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .byte_in     (byte_in),
        .last_byte   (last_byte),
        .empty       (empty),
        .pop         (pop),
        .unit_value  (unit_value),
        .last_of_run (last_of_run)
    );

    jamo_unit_checker u_chk
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .byte_in         (byte_in),
        .last_byte       (last_byte),
        .empty           (empty),
        .pop             (pop),
        .unit_value      (unit_value),
        .last_of_run     (last_of_run),
        .failures        (failures),
        .open_units      (open_units),
        .units_checked   (units_checked),
        .syllables_split (syllables_split),
        .tails_dropped   (tails_dropped),
        .bytes_skipped   (bytes_skipped)
    );

    // Clock with a 2 ns period.
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // The run is cut short if it goes on far too long.
    initial
    begin
        cycles_run = 0;
        while (cycles_run < RUN_LIMIT)
        begin
            @(posedge clk);
            cycles_run++;
        end
        $display("ERROR: run did not finish in %0d cycles", RUN_LIMIT);
        $display("utf8_decode_hangul_decompose_tb NOT OK");
        $finish;
    end

    // Cycles in which an offered item was held back.
    initial
    begin
        stall_cycles = 0;
        forever
        begin
            @(posedge clk);
            if (push && full)
            begin
                stall_cycles++;
            end
        end
    end

    // Offer one item, after an occasional gap, and wait until it is taken.
    task automatic send_byte(input logic [7:0] b, input logic fin);
        int gap;
        gap = (!quiet_tail && $urandom_range(0, 3) == 0) ? $urandom_range(1, 9) : 0;
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push      <= 1'b1;
        byte_in   <= b;
        last_byte <= fin;
        do @(posedge clk); while (full);
        bytes_sent++;
    endtask

    // Encode a code point in len bytes (overlong if it is small) and send the
    // first keep of them; each byte is now and then marked as the last.
    task automatic send_seq(input logic [20:0] cp, input int len, input int keep);
        logic [7:0] enc [4];
        case (len)
            1:
            begin
                enc[0] = {1'b0, cp[6:0]};
            end
            2:
            begin
                enc[0] = {3'b110, cp[10:6]};
                enc[1] = {2'b10, cp[5:0]};
            end
            3:
            begin
                enc[0] = {4'b1110, cp[15:12]};
                enc[1] = {2'b10, cp[11:6]};
                enc[2] = {2'b10, cp[5:0]};
            end
            default:
            begin
                enc[0] = {5'b11110, cp[20:18]};
                enc[1] = {2'b10, cp[17:12]};
                enc[2] = {2'b10, cp[11:6]};
                enc[3] = {2'b10, cp[5:0]};
            end
        endcase
        for (int i = 0; i < keep; i++)
        begin
            send_byte(enc[i], $urandom_range(0, 19) == 0);
        end
    endtask

    // Unit side: random pops and holds, one long hold to fill the block.
    initial
    begin
        pop       = 1'b0;
        hold_done = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (!hold_done && bytes_sent >= HOLD_AFTER)
            begin
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end
            else if (!quiet_tail && $urandom_range(0, 2) == 0)
            begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
            end
            else
            begin
                pop <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    end

    // Byte side: reset, directed cases, random text, then drain and verdict.
    initial
    begin : stimulus
        logic [20:0] cp;
        int          pick;
        int          random_end;
        int          len;

        push       = 1'b0;
        byte_in    = 8'h00;
        last_byte  = 1'b0;
        quiet_tail = 1'b0;
        bytes_sent = 0;
        rst_n      = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ASCII extremes, the second one closing the text.
        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b1);
        // Two byte form.
        send_byte(8'hC2, 1'b0);
        send_byte(8'hA9, 1'b0);
        // First syllable (no final jamo) and last syllable (with one).
        send_byte(8'hEA, 1'b0);
        send_byte(8'hB0, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hED, 1'b0);
        send_byte(8'h9E, 1'b0);
        send_byte(8'hA3, 1'b0);
        // Largest four byte value, truncated to 16 bits.
        send_byte(8'hF7, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b0);
        // Just past the syllable block.
        send_byte(8'hED, 1'b0);
        send_byte(8'h9E, 1'b0);
        send_byte(8'hA4, 1'b0);
        // Stray continuation and invalid lead bytes are skipped.
        send_byte(8'h80, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hF8, 1'b0);
        // ASCII taken as a continuation byte.
        send_byte(8'hC3, 1'b0);
        send_byte(8'h41, 1'b0);
        // Text that ends mid-sequence, and a lead byte as the final byte.
        send_byte(8'hE4, 1'b0);
        send_byte(8'hB8, 1'b1);
        send_byte(8'hC3, 1'b1);

        // Random text, mostly well-formed, with noise and cut-off sequences.
        random_end = bytes_sent + RANDOM_BYTES;
        while (bytes_sent < random_end)
        begin
            if (bytes_sent >= random_end - QUIET_BYTES)
            begin
                quiet_tail = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 20)
            begin
                send_seq(21'($urandom_range(0, 127)), 1, 1);
            end
            else if (pick < 35)
            begin
                send_seq(21'($urandom_range(0, 2047)), 2, 2);
            end
            else if (pick < 65)
            begin
                case ($urandom_range(0, 7))
                    0:       cp = 21'h00AC00;
                    1:       cp = 21'h00D7A3;
                    2:       cp = 21'h00ABFF;
                    3:       cp = 21'h00D7A4;
                    default: cp = 21'h00AC00 + 21'($urandom_range(0, 11171));
                endcase
                send_seq(cp, 3, 3);
            end
            else if (pick < 77)
            begin
                send_seq(21'($urandom_range(0, 65535)), 3, 3);
            end
            else if (pick < 87)
            begin
                send_seq(21'($urandom), 4, 4);
            end
            else if (pick < 93)
            begin
                // A sequence cut short; the next bytes finish it instead.
                len = $urandom_range(2, 4);
                send_seq(21'($urandom), len, $urandom_range(1, len - 1));
            end
            else
            begin
                send_byte(8'($urandom), $urandom_range(0, 19) == 0);
            end
        end
        push <= 1'b0;

        // Wait for every predicted unit, then for any stray late ones.
        do @(posedge clk); while (open_units != 0);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d bytes; checked %0d units, %0d syllables split into jamo.",
                 bytes_sent, units_checked, syllables_split);
        $display("Dropped %0d cut-off tails, skipped %0d bytes, input held back %0d cycles.",
                 tails_dropped, bytes_skipped, stall_cycles);
        if (failures == 0)
        begin
            $display("utf8_decode_hangul_decompose_tb OK");
        end
        else
        begin
            $display("ERROR: %0d mismatches", failures);
            $display("utf8_decode_hangul_decompose_tb NOT OK");
        end
        $finish;
    end

endmodule

### files.f
src/uhd_pkg.sv
src/uhd_fifo.sv
src/uhd_front.sv
src/uhd_back.sv
src/utf8_decode_hangul_decompose.sv
tb/sv/jamo_unit_checker.sv
tb/sv/utf8_decode_hangul_decompose_tb.sv
